### rtl/scfr_pkg.sv
// Package for the sector chain file reader: constants, codes and zone geometry.
`default_nettype none
package scfr_pkg;

    localparam int MAX_SECTORS = 8192;
    localparam int TRACK_COUNT = 35;
    localparam int TRACK_LIMIT = (TRACK_COUNT > 40) ? 40 : TRACK_COUNT;
    localparam int CNT_W       = 14;
    localparam int LAST_USED   = 254;

    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_op;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_READ = 1'b1
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN    = 3'd0,
        ST_DONE   = 3'd1,
        ST_BAD    = 3'd2,
        ST_CANCEL = 3'd3,
        ST_LIMIT  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_FIRST_TRACK  = 2'd0,
        CFG_FIRST_SECTOR = 2'd1,
        CFG_SIDE_BASE    = 2'd2,
        CFG_SIDE_LENGTH  = 2'd3
    } t_cfg_reg;

    localparam logic [18:0] SIDE_LENGTH_RST = 19'd174848;

    // Sectors on a track of the given zone
    function automatic logic [4:0] zone_sectors(input logic [7:0] t);
        logic [4:0] n;
        if (t <= 8'd17) begin
            n = 5'd21;
        end else if (t <= 8'd24) begin
            n = 5'd19;
        end else if (t <= 8'd30) begin
            n = 5'd18;
        end else begin
            n = 5'd17;
        end
        return n;
    endfunction

    // Linear index of sector 0 of a track; only meaningful for tracks 1 to 40
    function automatic logic [9:0] track_start(input logic [7:0] t);
        logic [9:0] tt;
        logic [9:0] s;
        tt = {2'b00, t};
        if (t <= 8'd17) begin
            s = 10'((tt - 10'd1) * 10'd21);
        end else if (t <= 8'd24) begin
            s = 10'(10'd357 + (tt - 10'd18) * 10'd19);
        end else if (t <= 8'd30) begin
            s = 10'(10'd490 + (tt - 10'd25) * 10'd18);
        end else begin
            s = 10'(10'd598 + (tt - 10'd31) * 10'd17);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/sector_chain_file_reader_core.sv
// Sector chain file reader: follows a file's sector links and streams its data bytes.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | i_valid / o_ready         | i_op, i_sector_byte, i_cancel
//  result   | o_valid / i_ready         | o_data_valid, o_data_byte, o_fetch_valid,
//           |                           | o_fetch_offset, o_finished, o_status
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
// One transaction in, one result out, with the result registered; a transaction can be
// taken every cycle. The result register sets the rate: o_ready is high whenever it
// is empty or being drained this cycle. A stall on the result side holds the input.
// Reset idles the reader and restores the configuration defaults.
`default_nettype none
module sector_chain_file_reader_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [18:0]          i_cfg_wdata,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_op,
    input  wire logic [7:0]           i_sector_byte,
    input  wire logic                 i_cancel,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_data_valid,
    output logic [7:0]                o_data_byte,
    output logic                      o_fetch_valid,
    output logic [18:0]               o_fetch_offset,
    output logic                      o_finished,
    output scfr_pkg::t_status         o_status
);
    import scfr_pkg::*;

    logic [7:0]  r_first_track;
    logic [7:0]  r_first_sector;
    logic [17:0] r_side_base;
    logic [18:0] r_side_length;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_link_track, n_link_track;
    logic [7:0]  r_link_sector, n_link_sector;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic        r_out_valid;
    logic        r_data_valid, n_data_valid;
    logic [7:0]  r_data_byte, n_data_byte;
    logic        r_fetch_valid, n_fetch_valid;
    logic [18:0] r_fetch_offset, n_fetch_offset;
    logic        r_finished, n_finished;
    t_status     r_status, n_status;

    logic        w_accept;
    logic        w_do_req;
    logic [7:0]  w_req_track;
    logic [7:0]  w_req_sector;
    logic [CNT_W-1:0] w_cnt_base;
    logic [9:0]  w_sec_index;
    logic [18:0] w_sec_end;
    logic [18:0] w_offset;
    logic [7:0]  w_used;
    logic [7:0]  w_data_idx;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_track  <= '0;
            r_first_sector <= '0;
            r_side_base    <= '0;
            r_side_length  <= SIDE_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FIRST_TRACK:  r_first_track  <= i_cfg_wdata[7:0];
                CFG_FIRST_SECTOR: r_first_sector <= i_cfg_wdata[7:0];
                CFG_SIDE_BASE:    r_side_base    <= i_cfg_wdata[17:0];
                CFG_SIDE_LENGTH:  r_side_length  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sector address and bounds of the requested sector
    assign w_sec_index = 10'(track_start(w_req_track) + {2'b00, w_req_sector});
    assign w_sec_end   = {1'b0, w_sec_index + 10'd1, 8'h00};
    assign w_offset    = 19'({1'b0, r_side_base} + {1'b0, w_sec_index, 8'h00});

    assign w_used     = (r_link_track == 8'd0 && r_link_sector >= 8'd1
                         && r_link_sector <= 8'(LAST_USED)) ? r_link_sector
                                                           : 8'(LAST_USED);
    assign w_data_idx = r_pos - 8'd2;

    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_link_track   = r_link_track;
        n_link_sector  = r_link_sector;
        n_cnt          = r_cnt;
        n_data_valid   = 1'b0;
        n_data_byte    = '0;
        n_fetch_valid  = 1'b0;
        n_fetch_offset = '0;
        n_finished     = 1'b0;
        n_status       = ST_RUN;
        w_do_req       = 1'b0;
        w_req_track    = r_link_track;
        w_req_sector   = r_link_sector;
        w_cnt_base     = r_cnt;

        if (t_op'(i_op) == OP_START) begin
            // abandon any chain in progress
            w_do_req      = 1'b1;
            w_req_track   = r_first_track;
            w_req_sector  = r_first_sector;
            w_cnt_base    = '0;
            n_link_track  = '0;
            n_link_sector = '0;
        end else if (r_phase == PH_READ) begin
            if (r_pos == 8'd0) begin
                n_link_track = i_sector_byte;
            end else if (r_pos == 8'd1) begin
                n_link_sector = i_sector_byte;
            end else if (w_data_idx < w_used) begin
                n_data_valid = 1'b1;
                n_data_byte  = i_sector_byte;
            end
            if (r_pos == 8'hFF) begin
                w_do_req = 1'b1;
            end else begin
                n_pos = r_pos + 8'd1;
            end
        end

        if (w_do_req) begin
            n_pos = '0;
            n_cnt = w_cnt_base;
            if (w_req_track == 8'd0) begin
                n_status = ST_DONE;
            end else if (w_cnt_base >= CNT_W'(MAX_SECTORS)) begin
                n_status = ST_LIMIT;
            end else if (i_cancel) begin
                n_status = ST_CANCEL;
            end else if (w_req_track > 8'(TRACK_LIMIT)
                         || w_req_sector >= {3'b000, zone_sectors(w_req_track)}) begin
                n_status = ST_BAD;
            end else if (w_sec_end > r_side_length) begin
                n_status = ST_BAD;
            end
            if (n_status == ST_RUN) begin
                n_fetch_valid  = 1'b1;
                n_fetch_offset = w_offset;
                n_cnt          = w_cnt_base + CNT_W'(1);
                n_phase        = PH_READ;
            end else begin
                n_finished = 1'b1;
                n_phase    = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_pos         <= '0;
            r_link_track  <= '0;
            r_link_sector <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase       <= n_phase;
                r_pos         <= n_pos;
                r_link_track  <= n_link_track;
                r_link_sector <= n_link_sector;
                r_cnt         <= n_cnt;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // result payload: load only on a new transaction, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_valid   <= n_data_valid;
            r_data_byte    <= n_data_byte;
            r_fetch_valid  <= n_fetch_valid;
            r_fetch_offset <= n_fetch_offset;
            r_finished     <= n_finished;
            r_status       <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_data_valid   = r_data_valid;
    assign o_data_byte    = r_data_byte;
    assign o_fetch_valid  = r_fetch_valid;
    assign o_fetch_offset = r_fetch_offset;
    assign o_finished     = r_finished;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_fetch_xor_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_fetch_valid && o_finished))
        else $error("fetch and finish in one result");

    a_status_tracks_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_finished == (o_status != ST_RUN)))
        else $error("status disagrees with finished");

    a_data_byte_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data_valid) |-> (o_data_byte == 8'd0))
        else $error("data byte set without data valid");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SECTORS))
        else $error("sector count beyond limit");

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_pos == 8'd0))
        else $error("byte position moved while idle");

    a_fetch_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_fetch_valid) |=> (r_phase == PH_READ && r_pos == 8'd0))
        else $error("fetch did not start a sector");
`endif

endmodule
`default_nettype wire
